[rtl/mvw_pkg.sv]
// Shared types, sizes and codes for the mesh vertex weld block.
// No dependencies; the RTL refers to it by scoped names, the testbench imports it.

package mvw_pkg;

   // Table sizes
   localparam int MAX_UNIQUE = 1024;
   localparam int MAX_INPUT  = 4096;

   localparam int UNIQ_AW  = $clog2(MAX_UNIQUE);      // unique-vertex address
   localparam int UCNT_W   = $clog2(MAX_UNIQUE + 1);  // unique count, holds MAX_UNIQUE
   localparam int INPUT_AW = $clog2(MAX_INPUT);       // input-position address
   localparam int ICNT_W   = $clog2(MAX_INPUT + 1);   // input count, holds MAX_INPUT

   // Fixed field widths
   localparam int COORD_W  = 24;
   localparam int TOL_W    = 23;
   localparam int IDX_W    = 12;
   localparam int ID_W     = 10;
   localparam int VERT_W   = 3 * COORD_W;

   // Distance datapath widths
   localparam int SQ_W     = 2 * COORD_W;   // one squared axis difference
   localparam int SUM_W    = SQ_W + 2;      // sum of three squares
   localparam int TOL2_W   = 2 * TOL_W;     // squared tolerance

   // Opcodes
   localparam logic [1:0] OP_WELD     = 2'd0;
   localparam logic [1:0] OP_REMAP    = 2'd1;
   localparam logic [1:0] OP_NEW_MESH = 2'd2;

   // Status codes
   localparam logic [1:0] STS_OK         = 2'd0;
   localparam logic [1:0] STS_FULL       = 2'd1;
   localparam logic [1:0] STS_EXHAUSTED  = 2'd2;
   localparam logic [1:0] STS_UNASSIGNED = 2'd3;

   typedef struct packed {
      logic [1:0]                opcode;
      logic signed [COORD_W-1:0] coord_x;
      logic signed [COORD_W-1:0] coord_y;
      logic signed [COORD_W-1:0] coord_z;
      logic [IDX_W-1:0]          original_index;
   } req_type;

   typedef struct packed {
      logic [ID_W-1:0] welded_id;
      logic            is_new;
      logic [1:0]      status;
   } rsp_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
   } vertex_type;

   // Compare result leaving the distance unit
   typedef struct packed {
      logic               vld;
      logic               hit;
      logic [UNIQ_AW-1:0] idx;
   } cmp_type;

endpackage

[rtl/mesh_vertex_weld.sv]
// Top level of the mesh vertex weld block: sequencer, counters and both tables.
// Depends on mvw_pkg, mvw_ram and mvw_dist.

// Channel  | ports                         | handshake
// ---------+-------------------------------+------------------------------------
// request  | start, busy, req_data         | beat taken when start && !busy
// response | rsp_valid, rsp_data           | one-cycle strobe, no back-pressure
// config   | csr_wr_en, csr_wr_data        | written on any edge with csr_wr_en
//
// Flow: a weld beat walks the unique-vertex memory one entry per cycle, through
// the memory read and the four-stage distance pipe to the response; a hit ends
// the walk early. A remap beat does one index-map read; start-new-mesh and
// unused opcodes are answered straight from idle.
// Reset clears the counts, the tolerance and the sequencer; memory contents are
// left as they are and are only read below the counts. The response side cannot
// stall, so busy depends only on the work in progress.

module mesh_vertex_weld (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  mvw_pkg::req_type            req_data,
   output logic                        rsp_valid,
   output mvw_pkg::rsp_type            rsp_data,
   input  logic                        csr_wr_en,
   input  logic [mvw_pkg::TOL_W-1:0]   csr_wr_data
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SCAN   = 4'b0010,
      ST_COMMIT = 4'b0100,
      ST_LOOKUP = 4'b1000
   } state_type;

   state_type                       state_ff, state_in;
   mvw_pkg::req_type                req_ff;
   logic [mvw_pkg::TOL_W-1:0]       tol_ff;
   logic [mvw_pkg::UCNT_W-1:0]      ucount_ff, ucount_in;
   logic [mvw_pkg::ICNT_W-1:0]      icount_ff, icount_in;
   logic [mvw_pkg::UCNT_W-1:0]      scan_k_ff, scan_k_in;
   logic                            hit_ff, hit_in;
   logic [mvw_pkg::UNIQ_AW-1:0]     hit_id_ff, hit_id_in;
   logic                            rd_vld_ff;
   logic [mvw_pkg::UNIQ_AW-1:0]     rd_idx_ff;
   logic                            rsp_valid_ff, rsp_valid_in;
   mvw_pkg::rsp_type                rsp_ff, rsp_in;

   logic                            accept;
   logic                            issue;
   logic                            vert_wr_en;
   logic [mvw_pkg::VERT_W-1:0]      vert_rd_data;
   logic                            map_wr_en;
   logic [mvw_pkg::UNIQ_AW-1:0]     map_wr_data;
   logic                            map_rd_en;
   logic [mvw_pkg::UNIQ_AW-1:0]     map_rd_data;
   mvw_pkg::vertex_type             probe;
   mvw_pkg::cmp_type                cmp;
   logic                            last_entry;

   assign accept = start && !busy;
   assign busy   = (state_ff != ST_IDLE);

   // Walk the table while entries remain below the count
   assign issue = (state_ff == ST_SCAN) && (scan_k_ff < ucount_ff);

   assign probe.x = req_ff.coord_x;
   assign probe.y = req_ff.coord_y;
   assign probe.z = req_ff.coord_z;

   assign last_entry = (mvw_pkg::UCNT_W'(cmp.idx) == ucount_ff - 1'b1);

   // Unique-vertex store: written on append, read by the walk
   mvw_ram #(
      .WIDTH (mvw_pkg::VERT_W),
      .DEPTH (mvw_pkg::MAX_UNIQUE)
   ) u_vert_ram (
      .clock   (clock),
      .wr_en   (vert_wr_en),
      .wr_addr (ucount_ff[mvw_pkg::UNIQ_AW-1:0]),
      .wr_data ({req_ff.coord_x, req_ff.coord_y, req_ff.coord_z}),
      .rd_en   (issue),
      .rd_addr (scan_k_ff[mvw_pkg::UNIQ_AW-1:0]),
      .rd_data (vert_rd_data)
   );

   // Index map: one id per input position, written in position order
   mvw_ram #(
      .WIDTH (mvw_pkg::UNIQ_AW),
      .DEPTH (mvw_pkg::MAX_INPUT)
   ) u_map_ram (
      .clock   (clock),
      .wr_en   (map_wr_en),
      .wr_addr (icount_ff[mvw_pkg::INPUT_AW-1:0]),
      .wr_data (map_wr_data),
      .rd_en   (map_rd_en),
      .rd_addr (mvw_pkg::INPUT_AW'(req_data.original_index)),
      .rd_data (map_rd_data)
   );

   mvw_dist u_dist (
      .clock     (clock),
      .reset     (reset),
      .flush     (state_ff != ST_SCAN),
      .tolerance (tol_ff),
      .ent_vld   (rd_vld_ff),
      .ent_idx   (rd_idx_ff),
      .ent_xyz   (mvw_pkg::vertex_type'(vert_rd_data)),
      .probe     (probe),
      .cmp       (cmp)
   );

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      ucount_in    = ucount_ff;
      icount_in    = icount_ff;
      scan_k_in    = scan_k_ff;
      hit_in       = hit_ff;
      hit_id_in    = hit_id_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = '0;
      vert_wr_en   = 1'b0;
      map_wr_en    = 1'b0;
      map_wr_data  = hit_id_ff;
      map_rd_en    = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_data.opcode)
                  mvw_pkg::OP_WELD: begin
                     if (icount_ff == mvw_pkg::ICNT_W'(mvw_pkg::MAX_INPUT)) begin
                        rsp_valid_in  = 1'b1;
                        rsp_in.status = mvw_pkg::STS_EXHAUSTED;
                     end else if (ucount_ff == '0) begin
                        // empty table: append straight away
                        hit_in   = 1'b0;
                        state_in = ST_COMMIT;
                     end else begin
                        scan_k_in = '0;
                        state_in  = ST_SCAN;
                     end
                  end
                  mvw_pkg::OP_REMAP: begin
                     if (32'(req_data.original_index) < 32'(icount_ff)) begin
                        map_rd_en = 1'b1;
                        state_in  = ST_LOOKUP;
                     end else begin
                        rsp_valid_in  = 1'b1;
                        rsp_in.status = mvw_pkg::STS_UNASSIGNED;
                     end
                  end
                  mvw_pkg::OP_NEW_MESH: begin
                     ucount_in    = '0;
                     icount_in    = '0;
                     rsp_valid_in = 1'b1;
                  end
                  default: begin
                     // unused opcode: answer and leave state alone
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end

         ST_SCAN: begin
            if (issue) begin
               scan_k_in = scan_k_ff + 1'b1;
            end
            // results leave the pipe in table order, so the first hit wins
            priority if (cmp.vld && cmp.hit) begin
               hit_in    = 1'b1;
               hit_id_in = cmp.idx;
               state_in  = ST_COMMIT;
            end else if (cmp.vld && last_entry) begin
               hit_in   = 1'b0;
               state_in = ST_COMMIT;
            end else begin
               // keep walking
               state_in = ST_SCAN;
            end
         end

         ST_COMMIT: begin
            state_in     = ST_IDLE;
            rsp_valid_in = 1'b1;
            priority if (hit_ff) begin
               map_wr_en        = 1'b1;
               map_wr_data      = hit_id_ff;
               icount_in        = icount_ff + 1'b1;
               rsp_in.welded_id = mvw_pkg::ID_W'(hit_id_ff);
            end else if (ucount_ff == mvw_pkg::UCNT_W'(mvw_pkg::MAX_UNIQUE)) begin
               rsp_in.status = mvw_pkg::STS_FULL;
            end else begin
               vert_wr_en       = 1'b1;
               map_wr_en        = 1'b1;
               map_wr_data      = ucount_ff[mvw_pkg::UNIQ_AW-1:0];
               ucount_in        = ucount_ff + 1'b1;
               icount_in        = icount_ff + 1'b1;
               rsp_in.welded_id = mvw_pkg::ID_W'(ucount_ff[mvw_pkg::UNIQ_AW-1:0]);
               rsp_in.is_new    = 1'b1;
            end
         end

         ST_LOOKUP: begin
            state_in         = ST_IDLE;
            rsp_valid_in     = 1'b1;
            rsp_in.welded_id = mvw_pkg::ID_W'(map_rd_data);
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ucount_ff    <= '0;
         icount_ff    <= '0;
         tol_ff       <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ucount_ff    <= ucount_in;
         icount_ff    <= icount_in;
         rd_vld_ff    <= issue;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            tol_ff <= csr_wr_data;
         end
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      scan_k_ff <= scan_k_in;
      hit_ff    <= hit_in;
      hit_id_ff <= hit_id_in;
      rd_idx_ff <= scan_k_ff[mvw_pkg::UNIQ_AW-1:0];
      rsp_ff    <= rsp_in;
      if (accept) begin
         req_ff <= req_data;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

[rtl/mvw_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.

module mvw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/mvw_dist.sv]
// Pipelined squared-distance compare: one stored vertex per cycle against the probe.
// Depends on mvw_pkg.

module mvw_dist (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             flush,
   input  logic [mvw_pkg::TOL_W-1:0]        tolerance,
   input  logic                             ent_vld,
   input  logic [mvw_pkg::UNIQ_AW-1:0]      ent_idx,
   input  mvw_pkg::vertex_type              ent_xyz,
   input  mvw_pkg::vertex_type              probe,
   output mvw_pkg::cmp_type                 cmp
);

   localparam int CW = mvw_pkg::COORD_W;

   logic signed [CW-1:0]            ea [3];
   logic signed [CW-1:0]            pa [3];
   logic signed [CW:0]              d_in [3];
   logic signed [CW:0]              d_ff [3];
   logic signed [2*CW+1:0]          prod [3];
   logic [mvw_pkg::SQ_W-1:0]        sq_ff [3];
   logic [mvw_pkg::SUM_W-1:0]       sum_ff;
   logic [mvw_pkg::TOL2_W-1:0]      tol2_ff;
   logic                            hit_ff;
   logic [3:0]                      vld_ff;
   logic [mvw_pkg::UNIQ_AW-1:0]     idx_ff [4];

   assign ea[0] = ent_xyz.x;
   assign ea[1] = ent_xyz.y;
   assign ea[2] = ent_xyz.z;
   assign pa[0] = probe.x;
   assign pa[1] = probe.y;
   assign pa[2] = probe.z;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         d_in[i] = {ea[i][CW-1], ea[i]} - {pa[i][CW-1], pa[i]};
         prod[i] = d_ff[i] * d_ff[i];
      end
   end

   // Datapath: difference, square, sum, compare
   always_ff @(posedge clock) begin
      tol2_ff <= mvw_pkg::TOL2_W'(tolerance) * mvw_pkg::TOL2_W'(tolerance);
      for (int i = 0; i < 3; i++) begin
         d_ff[i]  <= d_in[i];
         sq_ff[i] <= prod[i][mvw_pkg::SQ_W-1:0];
      end
      sum_ff <= mvw_pkg::SUM_W'(sq_ff[0]) + mvw_pkg::SUM_W'(sq_ff[1])
              + mvw_pkg::SUM_W'(sq_ff[2]);
      hit_ff <= sum_ff < mvw_pkg::SUM_W'(tol2_ff);
      idx_ff[0] <= ent_idx;
      for (int s = 1; s < 4; s++) begin
         idx_ff[s] <= idx_ff[s-1];
      end
   end

   // Drop everything in flight on flush
   always_ff @(posedge clock) begin
      if (reset || flush) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[2:0], ent_vld};
      end
   end

   assign cmp.vld = vld_ff[3];
   assign cmp.hit = hit_ff;
   assign cmp.idx = idx_ff[3];

endmodule

[rtl/mvw_checker.sv]
// Port-level checks for mesh_vertex_weld, attached by the bind at the bottom.
// Depends on mvw_pkg and mesh_vertex_weld.

module mvw_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             busy,
   input  logic             rsp_valid,
   input  mvw_pkg::rsp_type rsp_data
);

   // An accepted beat is either being worked on or answered next cycle
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy || rsp_valid)
      else $error("accepted beat neither in progress nor answered");

   // A response only follows work or an accept
   a_rsp_has_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy) || $past(start))
      else $error("response without a preceding beat");

   // An append is always a clean result
   a_new_is_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.is_new |-> rsp_data.status == mvw_pkg::STS_OK)
      else $error("new vertex reported with error status");

   // Error results carry id zero and no append
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != mvw_pkg::STS_OK
         |-> rsp_data.welded_id == '0 && !rsp_data.is_new)
      else $error("error result with nonzero id or append flag");

   // Reset leaves the block idle and quiet
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !busy && !rsp_valid)
      else $error("block not idle after reset");

endmodule

bind mesh_vertex_weld mvw_checker u_mvw_checker (.*);

[test/mesh_vertex_weld_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for mesh_vertex_weld: directed, table-limit and random mesh tests.
// Depends on mvw_pkg and the mesh_vertex_weld RTL only; the expected beats come from a
// behavioral weld predictor kept inside this file.

module mesh_vertex_weld_tb;
   import mvw_pkg::*;

   // Opcode the block must ignore; the package names only the three live ones
   localparam logic [1:0] OP_UNUSED = 2'd3;

   localparam logic [TOL_W-1:0]          TOL_MAX   = '1;
   localparam logic signed [COORD_W-1:0] COORD_MAX = 24'sh7FFFFF;
   localparam logic signed [COORD_W-1:0] COORD_MIN = 24'sh800000;

   localparam int RANDOM_ITEMS  = 580;
   localparam int QUIET_TAIL    = 80;        // last random beats sent with no idling
   localparam int SETTLE_CYCLES = 12;        // > read latency plus distance pipe
   localparam int CYCLE_LIMIT   = 4_000_000; // room for the full-table fill and its whole-table walks
   localparam int REPORT_MAX    = 10;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_valid;
   rsp_type rsp_data;
   logic    csr_wr_en = 1'b0;
   logic [TOL_W-1:0] csr_wr_data = '0;

   // Predictor state: unique-vertex table, position-to-id map, counts, tolerance
   vertex_type       weld_table [MAX_UNIQUE];
   logic [ID_W-1:0]  pos_to_id  [MAX_INPUT];
   int unsigned      uniq_cnt;
   int unsigned      pos_cnt;
   logic [TOL_W-1:0] tol_reg;

   rsp_type    awaited_rsp[$];   // welder responses still due, oldest first
   int         err_count;
   int         cycle_count;
   bit         idle_on;          // sender inserts random gaps when set
   vertex_type cluster_ctr [8];

   mesh_vertex_weld DUT (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #2 clock = ~clock;

   // Guard against a hung handshake; count every rising edge
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   //------------------------------------------------------------------
   // Predictor
   //------------------------------------------------------------------

   function automatic logic [63:0] axis_sq(logic signed [COORD_W-1:0] a,
                                           logic signed [COORD_W-1:0] b);
      longint d;
      d = longint'(a) - longint'(b);
      if (d < 0) d = -d;
      return d * d;
   endfunction

   // Apply one accepted beat to the predictor state and return the response it must give
   function automatic rsp_type predict_weld(req_type item);
      rsp_type     r;
      vertex_type  v;
      logic [63:0] tol2;
      logic [63:0] d2;
      bit          hit;
      int unsigned k;
      int unsigned id;
      r   = '0;
      hit = 1'b0;
      id  = 0;
      case (item.opcode)
         OP_WELD: begin
            if (pos_cnt >= MAX_INPUT) begin
               r.status = STS_EXHAUSTED;
            end else begin
               v.x  = item.coord_x;
               v.y  = item.coord_y;
               v.z  = item.coord_z;
               tol2 = 64'(tol_reg) * 64'(tol_reg);
               // first entry strictly inside the tolerance wins
               for (k = 0; k < uniq_cnt && !hit; k++) begin
                  d2 = axis_sq(weld_table[k].x, v.x) + axis_sq(weld_table[k].y, v.y)
                     + axis_sq(weld_table[k].z, v.z);
                  if (d2 < tol2) begin
                     hit = 1'b1;
                     id  = k;
                  end
               end
               if (hit) begin
                  pos_to_id[pos_cnt] = ID_W'(id);
                  pos_cnt++;
                  r.welded_id = ID_W'(id);
               end else if (uniq_cnt >= MAX_UNIQUE) begin
                  r.status = STS_FULL;
               end else begin
                  weld_table[uniq_cnt] = v;
                  pos_to_id[pos_cnt]   = ID_W'(uniq_cnt);
                  r.welded_id          = ID_W'(uniq_cnt);
                  r.is_new             = 1'b1;
                  uniq_cnt++;
                  pos_cnt++;
               end
            end
         end
         OP_REMAP: begin
            if (item.original_index < pos_cnt)
               r.welded_id = pos_to_id[item.original_index];
            else
               r.status = STS_UNASSIGNED;
         end
         OP_NEW_MESH: begin
            uniq_cnt = 0;
            pos_cnt  = 0;
         end
         default: ;
      endcase
      return r;
   endfunction

   //------------------------------------------------------------------
   // Beat builders
   //------------------------------------------------------------------

   function automatic req_type make_req(logic [1:0] op, vertex_type v, int unsigned idx);
      req_type r;
      r.opcode         = op;
      r.coord_x        = v.x;
      r.coord_y        = v.y;
      r.coord_z        = v.z;
      r.original_index = IDX_W'(idx);
      return r;
   endfunction

   function automatic vertex_type make_vertex(int x, int y, int z);
      vertex_type v;
      v.x = x[COORD_W-1:0];
      v.y = y[COORD_W-1:0];
      v.z = z[COORD_W-1:0];
      return v;
   endfunction

   function automatic vertex_type rand_vertex();
      vertex_type v;
      v.x = COORD_W'($urandom);
      v.y = COORD_W'($urandom);
      v.z = COORD_W'($urandom);
      return v;
   endfunction

   // Jitter each axis of c by up to +/- j; let it wrap at the coordinate width
   function automatic vertex_type near_vertex(vertex_type c, int j);
      return make_vertex(int'(c.x) + int'($urandom_range(0, 2 * j)) - j,
                         int'(c.y) + int'($urandom_range(0, 2 * j)) - j,
                         int'(c.z) + int'($urandom_range(0, 2 * j)) - j);
   endfunction

   function automatic req_type weld_req(vertex_type v);
      return make_req(OP_WELD, v, $urandom_range(0, 4095));
   endfunction

   function automatic req_type remap_req(int unsigned idx);
      return make_req(OP_REMAP, rand_vertex(), idx);
   endfunction

   function automatic req_type ctl_req(logic [1:0] op);
      return make_req(op, rand_vertex(), $urandom_range(0, 4095));
   endfunction

   //------------------------------------------------------------------
   // Driver side; every task starts and ends just after a falling edge
   //------------------------------------------------------------------

   // Present one beat, hold it until taken, then predict its response.
   // Leave start high on return so the next beat can follow without a gap.
   task automatic send_beat(req_type item);
      int      gap;
      rsp_type due;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         gap   = $urandom_range(1, 4);
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start    <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (busy !== 1'b0);
      due = predict_weld(item);
      awaited_rsp.insert(awaited_rsp.size(), due);
      @(negedge clock);
   endtask

   // Drop start, wait for every due response, then let the pipe drain
   task automatic settle_until_idle();
      start <= 1'b0;
      while (awaited_rsp.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Only called while idle, right after settle_until_idle
   task automatic write_tolerance(logic [TOL_W-1:0] tol);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= tol;
      tol_reg      = tol;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      @(negedge clock);
   endtask

   //------------------------------------------------------------------
   // Response checker: one strobe per beat, no back-pressure possible
   //------------------------------------------------------------------

   task automatic log_mismatch(string what, rsp_type want, rsp_type got);
      err_count++;
      if (err_count <= REPORT_MAX)
         $display("%s: expected id=%0d new=%0b status=%0d, got id=%0d new=%0b status=%0d",
                  what, want.welded_id, want.is_new, want.status,
                  got.welded_id, got.is_new, got.status);
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (awaited_rsp.size() == 0) begin
            log_mismatch("unexpected response", '0, rsp_data);
         end else begin
            want = awaited_rsp.pop_front();
            if (rsp_data.welded_id !== want.welded_id || rsp_data.is_new !== want.is_new ||
                rsp_data.status !== want.status)
               log_mismatch("response mismatch", want, rsp_data);
         end
      end
   end

   //------------------------------------------------------------------
   // Tests
   //------------------------------------------------------------------

   // Boundary cases: tolerance zero, exact tolerance distance, coordinate extremes,
   // unassigned and edge indices, ignored opcode, new mesh
   task automatic test_directed_cases();
      vertex_type origin;
      origin  = make_vertex(0, 0, 0);
      idle_on = 1'b0;
      // nothing welded yet: any index is unassigned
      send_beat(remap_req(0));
      send_beat(ctl_req(OP_UNUSED));
      // reset tolerance is zero: identical vertices still stay apart
      send_beat(weld_req(origin));
      send_beat(weld_req(origin));
      settle_until_idle();
      write_tolerance(TOL_W'(4096));   // 1.0 in Q11.12
      send_beat(ctl_req(OP_NEW_MESH));
      send_beat(weld_req(origin));
      send_beat(weld_req(make_vertex(4096, 0, 0)));   // distance equals tolerance: new
      send_beat(weld_req(make_vertex(4095, 0, 0)));   // just inside: first entry wins
      send_beat(weld_req(make_vertex(8191, 0, 0)));   // inside second entry only
      send_beat(weld_req(make_vertex(0, -4095, 0)));
      send_beat(weld_req(make_vertex(COORD_MAX, COORD_MAX, COORD_MAX)));
      send_beat(weld_req(make_vertex(COORD_MIN, COORD_MIN, COORD_MIN)));
      send_beat(weld_req(make_vertex(COORD_MAX, COORD_MIN, COORD_MAX)));
      send_beat(remap_req(0));
      send_beat(remap_req(pos_cnt - 1));
      send_beat(remap_req(pos_cnt));         // first unassigned position
      send_beat(remap_req(4095));
      settle_until_idle();
      write_tolerance(TOL_MAX);
      send_beat(weld_req(make_vertex(0, 0, 1)));
      send_beat(weld_req(make_vertex(COORD_MIN, COORD_MIN, COORD_MIN)));
      send_beat(weld_req(make_vertex(COORD_MIN, COORD_MAX, COORD_MIN)));
      send_beat(ctl_req(OP_UNUSED));
      send_beat(ctl_req(OP_NEW_MESH));
      send_beat(remap_req(0));               // counts cleared
   endtask

   // Fill the unique table, overflow it, then use up every input position
   task automatic test_table_limits();
      vertex_type anchor;
      int         n;
      settle_until_idle();
      write_tolerance('0);
      idle_on = 1'b1;
      send_beat(ctl_req(OP_NEW_MESH));
      // tolerance zero never merges, so each beat appends and walks the whole table
      for (n = 0; n < MAX_UNIQUE; n++) send_beat(weld_req(rand_vertex()));
      send_beat(weld_req(rand_vertex()));    // table full
      send_beat(remap_req(MAX_UNIQUE - 1));
      send_beat(remap_req(MAX_UNIQUE));      // the full-table beat took no position
      settle_until_idle();
      write_tolerance(TOL_MAX);
      anchor = weld_table[0];
      // hits on the first entry end the walk early
      while (pos_cnt < MAX_INPUT) send_beat(weld_req(near_vertex(anchor, 1024)));
      send_beat(weld_req(anchor));           // positions exhausted
      send_beat(weld_req(rand_vertex()));
      send_beat(remap_req(4095));
      send_beat(remap_req($urandom_range(0, 4095)));
      send_beat(ctl_req(OP_NEW_MESH));
      send_beat(remap_req(4095));
   endtask

   // Random meshes: mostly clustered welds with remaps, some noise beats
   task automatic test_random_meshes();
      int               sent;
      int               phase;
      int               m;
      int               pick;
      int               jit;
      logic [TOL_W-1:0] tol;
      vertex_type       v;
      sent  = 0;
      phase = 0;
      while (sent < RANDOM_ITEMS) begin
         // hold the sender until every response is in before touching the tolerance
         settle_until_idle();
         case (phase % 5)
            0:       tol = '0;
            1:       tol = TOL_MAX;
            2:       tol = TOL_W'($urandom_range(1, 16));
            3:       tol = TOL_W'($urandom_range(256, 16384));
            default: tol = TOL_W'($urandom);
         endcase
         write_tolerance(tol);
         jit = (tol == 0) ? 2 : ((tol > 20000) ? 20000 : int'(tol));
         foreach (cluster_ctr[i]) cluster_ctr[i] = rand_vertex();
         for (m = 0; m < 3 && sent < RANDOM_ITEMS; m++) begin
            idle_on = (sent < RANDOM_ITEMS - QUIET_TAIL) && ($urandom_range(0, 3) != 0);
            send_beat(ctl_req(OP_NEW_MESH));
            sent++;
            repeat ($urandom_range(8, 40)) begin
               pick = $urandom_range(0, 99);
               v    = cluster_ctr[$urandom_range(0, 7)];
               if (pick < 8)
                  send_beat(weld_req(v));
               else if (pick < 62)
                  send_beat(weld_req(near_vertex(v, jit)));
               else if (pick < 74)
                  send_beat(weld_req(rand_vertex()));
               else if (pick < 86)
                  send_beat(remap_req($urandom_range(0, pos_cnt)));
               else if (pick < 94)
                  send_beat(remap_req($urandom_range(0, 4095)));
               else if (pick < 98)
                  send_beat(ctl_req(OP_UNUSED));
               else
                  send_beat(ctl_req(OP_NEW_MESH));
               sent++;
            end
         end
         phase++;
      end
   endtask

   //------------------------------------------------------------------
   // Sequence
   //------------------------------------------------------------------

   initial begin
      uniq_cnt    = 0;
      pos_cnt     = 0;
      tol_reg     = '0;
      err_count   = 0;
      cycle_count = 0;
      idle_on     = 1'b0;
      // synchronous reset held from time zero, released on a falling edge
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_directed_cases();
      test_table_limits();
      test_random_meshes();

      // drain: all beats taken, wait out every response and the pipe
      settle_until_idle();
      if (err_count == 0 && awaited_rsp.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
